// File: rtl/lphs_pkg.sv
package lphs_pkg;

  // Field widths of the beats
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 13;
  localparam int EVENT_W  = 32;
  localparam int LIMIT_W  = 7;

  // Probe limit bounds and reset value
  localparam logic [LIMIT_W-1:0] MAX_PROBES  = 7'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Operation codes carried on in_tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TEST   = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PRESENT   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_NULL_KEY  = 3'd4
  } status_t;

endpackage

// File: rtl/lphs_ram.sv
module lphs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/linear_probe_hash_set_top.sv
// Insert-only hash set of 64-bit keys with linear probing.
// Input channel: in_tdata carries the key, in_tuser the operation
// (0 insert, 1 membership test). One result beat leaves on the output
// channel for every input beat, in order: status, occupancy after the
// operation and the saturating near-full event count.
// A zero key is the null key; it returns the null-key status at once.
// An operation is accepted in S_IDLE, which reads the home slot; S_PROBE checks
// the slots, S_RESP registers the result (a null key goes straight to S_RESP),
// and the slot RAM with its registered read sets the one-slot-per-cycle probe rate.
// One item is worked on at a time, so a new beat is taken only after the
// previous result is registered; the next one is taken while the previous
// result still waits in the output register.
// cfg_wr_en writes the probe limit (0 acts as 1, above 64 acts as 64).
// After reset the block sweeps all 2^TABLE_BITS slots of the RAM to empty, one
// slot a cycle, and holds in_tready low meanwhile.
// A stalled receiver keeps the result in the output register; once a new
// result is ready behind it the block waits and accepts nothing more.
module linear_probe_hash_set_top
  import lphs_pkg::*;
#(
  parameter int TABLE_BITS  = 12,
  parameter int FULL_MARGIN = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [LIMIT_W-1:0]  cfg_wr_data,  // probe_limit
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [KEY_W-1:0]    in_tdata,     // [63:0] key
  input  logic                in_tuser,     // [0] op
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata     // [2:0] status, [15:3] occupancy,
                                            // [47:16] near_full_count
);

  localparam int SLOT_COUNT = 1 << TABLE_BITS;
  localparam int CNT_W      = (TABLE_BITS + 1 > OCC_W) ? TABLE_BITS + 1 : OCC_W;
  localparam int NEAR_TH    = (FULL_MARGIN >= SLOT_COUNT) ? 0 : SLOT_COUNT - FULL_MARGIN;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE, S_RESP} state_t;

  state_t                  state_r, state_nxt;
  logic [TABLE_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic [TABLE_BITS-1:0]   slot_r, slot_nxt;
  logic [LIMIT_W-1:0]      probe_r, probe_nxt;
  logic [LIMIT_W-1:0]      lim_r, lim_nxt;
  logic [LIMIT_W-1:0]      limit_r;
  logic                    op_r, op_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  status_t                 res_r, res_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [EVENT_W-1:0]      sat_r, sat_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [47:0]             out_data_r, out_data_nxt;

  logic                    ram_we;
  logic [TABLE_BITS-1:0]   ram_waddr, ram_raddr;
  logic [KEY_W-1:0]        ram_wdata, ram_rdata;
  logic                    bump;
  logic                    out_free;
  logic [LIMIT_W-1:0]      eff_limit;

  lphs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clamp the programmed limit to 1..64
  always_comb begin
    if (limit_r == '0) begin
      eff_limit = 7'd1;
    end else if (limit_r > MAX_PROBES) begin
      eff_limit = MAX_PROBES;
    end else begin
      eff_limit = limit_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Read the home slot on accept, the next slot while probing
  assign ram_raddr = (state_r == S_IDLE) ? in_tdata[TABLE_BITS+3:4] : slot_r + 1'b1;

  // Next-state and datapath
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    lim_nxt       = lim_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = key_r;
    bump          = 1'b0;

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {TABLE_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          key_nxt   = in_tdata;
          slot_nxt  = in_tdata[TABLE_BITS+3:4];
          probe_nxt = '0;
          lim_nxt   = eff_limit;
          if (in_tdata == '0) begin
            res_nxt   = ST_NULL_KEY;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (ram_rdata == key_r) begin
          res_nxt   = ST_PRESENT;
          state_nxt = S_RESP;
        end else if (ram_rdata == '0) begin
          if (op_r == OP_INSERT) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            bump    = (cnt_nxt >= CNT_W'(NEAR_TH));
            res_nxt = ST_INSERTED;
          end else begin
            res_nxt = ST_ABSENT;
          end
          state_nxt = S_RESP;
        end else if (probe_r + 1'b1 == lim_r) begin
          if (op_r == OP_INSERT) begin
            bump    = 1'b1;
            res_nxt = ST_EXHAUSTED;
          end else begin
            res_nxt = ST_ABSENT;
          end
          state_nxt = S_RESP;
        end else begin
          // advance to the next slot, read already issued
          probe_nxt = probe_r + 1'b1;
          slot_nxt  = slot_r + 1'b1;
        end
        if (bump && sat_r != {EVENT_W{1'b1}}) begin
          sat_nxt = sat_r + 1'b1;
        end
      end
      S_RESP: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {sat_r, cnt_r[OCC_W-1:0], res_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      sat_r       <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
    slot_r     <= slot_nxt;
    probe_r    <= probe_nxt;
    lim_r      <= lim_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_no_null_store: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != S_CLEAR) |-> (ram_wdata != '0))
    else $error("null key written into slot table");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOT_COUNT))
    else $error("occupancy exceeds table size");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (probe_r < lim_r && lim_r != '0))
    else $error("probe count beyond limit");

  a_sat_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (sat_r >= $past(sat_r)))
    else $error("saturation count decreased");
`endif

endmodule

// File: tb/linear_probe_hash_set_top_test.sv
module linear_probe_hash_set_top_test
  import lphs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_BITS    = 12;
  localparam int SLOTS       = 1 << TBL_BITS;
  localparam int MARGIN      = 1024;
  localparam int WATCHDOG    = 20000;
  localparam int LONG_HOLD   = 400;
  localparam int FILL_ITEMS  = 380;
  localparam int PHASE_ITEMS = 150;
  localparam int OCC_LO      = STATUS_W;
  localparam int EV_LO       = STATUS_W + OCC_W;

  typedef struct packed {
    status_t              status;
    logic [OCC_W-1:0]     occ;
    logic [EVENT_W-1:0]   events;
  } result_t;

  // One row of the directed walk: either a probe limit write or one operation
  typedef struct packed {
    logic                 is_cfg;
    logic [LIMIT_W-1:0]   lim;
    logic                 op;
    logic [KEY_W-1:0]     key;
    logic                 typed;
    result_t              res;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_TOGGLE, RX_MOSTLY_READY, RX_MOSTLY_STALLED} rx_mode_t;

  localparam result_t NO_RES = '{ST_PRESENT, 13'd0, 32'd0};

  localparam dir_row_t DIRECTED [25] = '{
    '{1'b0, 7'd0,   OP_INSERT, 64'h0,                   1'b1, '{ST_NULL_KEY,  13'd0, 32'd0}},
    '{1'b0, 7'd0,   OP_TEST,   64'h0,                   1'b1, '{ST_NULL_KEY,  13'd0, 32'd0}},
    '{1'b0, 7'd0,   OP_TEST,   64'h10,                  1'b1, '{ST_ABSENT,    13'd0, 32'd0}},
    '{1'b0, 7'd0,   OP_INSERT, 64'h10,                  1'b1, '{ST_INSERTED,  13'd1, 32'd0}},
    '{1'b0, 7'd0,   OP_INSERT, 64'h10,                  1'b1, '{ST_PRESENT,   13'd1, 32'd0}},
    '{1'b0, 7'd0,   OP_TEST,   64'h10,                  1'b1, '{ST_PRESENT,   13'd1, 32'd0}},
    '{1'b0, 7'd0,   OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_INSERTED,  13'd2, 32'd0}},
    '{1'b0, 7'd0,   OP_INSERT, 64'h0000_0000_0000_FFF1, 1'b1, '{ST_INSERTED,  13'd3, 32'd0}},
    '{1'b0, 7'd0,   OP_INSERT, 64'h8000_0000_0000_FFF2, 1'b1, '{ST_INSERTED,  13'd4, 32'd0}},
    '{1'b0, 7'd0,   OP_TEST,   64'h8000_0000_0000_FFF2, 1'b1, '{ST_PRESENT,   13'd4, 32'd0}},
    '{1'b0, 7'd0,   OP_TEST,   64'h1,                   1'b1, '{ST_ABSENT,    13'd4, 32'd0}},
    '{1'b0, 7'd0,   OP_INSERT, 64'h1,                   1'b1, '{ST_INSERTED,  13'd5, 32'd0}},
    '{1'b1, 7'd1,   OP_INSERT, 64'h0,                   1'b0, NO_RES},
    '{1'b0, 7'd0,   OP_INSERT, 64'h20,                  1'b1, '{ST_EXHAUSTED, 13'd5, 32'd1}},
    '{1'b0, 7'd0,   OP_TEST,   64'h20,                  1'b1, '{ST_ABSENT,    13'd5, 32'd1}},
    '{1'b0, 7'd0,   OP_TEST,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_PRESENT,   13'd5, 32'd1}},
    '{1'b1, 7'd0,   OP_INSERT, 64'h0,                   1'b0, NO_RES},
    '{1'b0, 7'd0,   OP_INSERT, 64'h30,                  1'b1, '{ST_EXHAUSTED, 13'd5, 32'd2}},
    '{1'b0, 7'd0,   OP_TEST,   64'h1,                   1'b1, '{ST_ABSENT,    13'd5, 32'd2}},
    '{1'b1, 7'd127, OP_INSERT, 64'h0,                   1'b0, NO_RES},
    '{1'b0, 7'd0,   OP_INSERT, 64'h30,                  1'b1, '{ST_INSERTED,  13'd6, 32'd2}},
    '{1'b0, 7'd0,   OP_INSERT, 64'h7FFF_FFFF_FFFF_FFF0, 1'b0, NO_RES},
    '{1'b0, 7'd0,   OP_TEST,   64'h7FFF_FFFF_FFFF_FFF0, 1'b0, NO_RES},
    '{1'b1, 7'd64,  OP_INSERT, 64'h0,                   1'b0, NO_RES},
    '{1'b0, 7'd0,   OP_INSERT, 64'h5555_AAAA_5555_AAA0, 1'b0, NO_RES}
  };

  localparam logic [LIMIT_W-1:0] PHASE_LIMITS [8] = '{
    7'd64, 7'd2, 7'd0, 7'd127, 7'd1, 7'd100, 7'd8, 7'd33
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [LIMIT_W-1:0]  cfg_wr_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [KEY_W-1:0]    in_tdata;     // [63:0] key
  logic                in_tuser;     // [0] op
  logic                out_tvalid;
  logic                out_tready;
  logic [47:0]         out_tdata;    // [2:0] status, [15:3] occupancy, [47:16] near_full_count

  // Shadow of the set and its counters
  logic [KEY_W-1:0]    slot_mem [SLOTS];
  int unsigned         fill_count;
  logic [EVENT_W-1:0]  event_count;
  logic [LIMIT_W-1:0]  probe_lim_q;

  result_t             pending_results [$];
  logic [KEY_W-1:0]    key_pool [$];
  logic [TBL_BITS-1:0] window_base;
  int                  burst_left;
  bit                  no_gaps;
  bit                  long_hold;
  int                  mismatches;
  int                  idle_cycles;

  linear_probe_hash_set_top #(
    .TABLE_BITS  (TBL_BITS),
    .FULL_MARGIN (MARGIN)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Walk the probe sequence, store on insert and update both counters
  function automatic result_t predict_op(input logic op, input logic [KEY_W-1:0] key);
    result_t     r;
    int unsigned home;
    int unsigned lim;
    int unsigned p;
    int unsigned idx;
    bit          done;
    done = 1'b0;
    if (key == '0) begin
      r.status = ST_NULL_KEY;
    end else begin
      home = key[TBL_BITS+3:4];
      lim = probe_lim_q;
      if (lim == 0) lim = 1;
      if (lim > MAX_PROBES) lim = MAX_PROBES;
      r.status = (op == OP_INSERT) ? ST_EXHAUSTED : ST_ABSENT;
      for (p = 0; p < lim && !done; p++) begin
        idx = (home + p) % SLOTS;
        if (slot_mem[idx] == key) begin
          r.status = ST_PRESENT;
          done = 1'b1;
        end else if (slot_mem[idx] == '0) begin
          if (op == OP_INSERT) begin
            slot_mem[idx] = key;
            fill_count++;
            if (fill_count + MARGIN >= SLOTS && event_count != '1) event_count++;
            r.status = ST_INSERTED;
          end else begin
            r.status = ST_ABSENT;
          end
          done = 1'b1;
        end
      end
      // exhausted insert counts as a saturation event
      if (!done && op == OP_INSERT && event_count != '1) event_count++;
    end
    r.occ    = fill_count[OCC_W-1:0];
    r.events = event_count;
    return r;
  endfunction

  // Mix of null keys, known keys, clustered home slots and fully random keys
  function automatic logic [KEY_W-1:0] draw_key();
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    k = {$urandom, $urandom};
    if (pick < 5) begin
      k = '0;
    end else if (pick < 35 && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (pick < 70) begin
      k[TBL_BITS+3:4] = window_base + TBL_BITS'($urandom_range(0, 11));
    end
    return k;
  endfunction

  // Offer one beat, hold it until accepted, then record its expected result
  task automatic offer_item(input logic op, input logic [KEY_W-1:0] key,
                            input bit typed, input result_t given);
    result_t r;
    int      gap;
    gap = 0;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 10);
      end
      burst_left--;
    end
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    r = predict_op(op, key);
    pending_results.push_back(typed ? given : r);
    if (key != '0) key_pool.push_back(key);
  endtask

  task automatic offer_random();
    logic op;
    op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_TEST;
    offer_item(op, draw_key(), 1'b0, NO_RES);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
  endtask

  task automatic write_probe_limit(input logic [LIMIT_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    probe_lim_q = value;
  endtask

  // Receiver stall pattern, with one long hold on request
  initial begin : rx_pattern
    rx_mode_t mode;
    int       left;
    out_tready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          RX_OPEN:         out_tready <= 1'b1;
          RX_TOGGLE:       out_tready <= ~out_tready;
          RX_MOSTLY_READY: out_tready <= ($urandom_range(0, 9) < 7);
          default:         out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t head;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", out_tdata);
      end else begin
        head = pending_results.pop_front();
        if (out_tdata[STATUS_W-1:0] !== head.status ||
            out_tdata[EV_LO-1:OCC_LO] !== head.occ ||
            out_tdata[EV_LO+EVENT_W-1:EV_LO] !== head.events) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d occupancy %0d/%0d events %0d/%0d (exp/got)",
                     head.status, out_tdata[STATUS_W-1:0],
                     head.occ, out_tdata[EV_LO-1:OCC_LO],
                     head.events, out_tdata[EV_LO+EVENT_W-1:EV_LO]);
        end
      end
    end
  end

  // End the run when neither side moves a beat for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int ph;
    int n;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_INSERT;
    for (i = 0; i < SLOTS; i++) slot_mem[i] = '0;
    fill_count  = 0;
    event_count = '0;
    probe_lim_q = LIMIT_RESET;
    window_base = '0;
    burst_left  = 0;
    no_gaps     = 1'b0;
    long_hold   = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk: null keys, wraparound, limit extremes
    for (i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].is_cfg) write_probe_limit(DIRECTED[i].lim);
      else offer_item(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].res);
    end

    // Random phases over a spread of probe limits
    for (ph = 0; ph < $size(PHASE_LIMITS); ph++) begin
      write_probe_limit(PHASE_LIMITS[ph]);
      window_base = (ph == 3) ? 12'hFFC : TBL_BITS'($urandom_range(0, SLOTS - 1));
      no_gaps = (ph == 1) || ($urandom_range(0, 3) == 0);
      if (ph == 1) long_hold = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS / 2) settle();
        offer_random();
      end
    end

    // Crowd the table with fresh keys
    no_gaps = 1'b0;
    write_probe_limit(MAX_PROBES);
    repeat (FILL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) offer_item(OP_TEST, draw_key(), 1'b0, NO_RES);
      else offer_item(OP_INSERT, {$urandom, $urandom}, 1'b0, NO_RES);
    end

    // Short probes on a crowded table
    write_probe_limit(7'd4);
    window_base = TBL_BITS'($urandom_range(0, SLOTS - 1));
    repeat (PHASE_ITEMS) offer_random();

    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: linear_probe_hash_set_top.f
rtl/lphs_pkg.sv
rtl/lphs_ram.sv
rtl/linear_probe_hash_set_top.sv
tb/linear_probe_hash_set_top_test.sv
